// File: sv/dh_handshake_xor_stream_macros.svh
// Assertion macros used by the checker file.
`ifndef DH_HANDSHAKE_XOR_STREAM_MACROS_SVH
`define DH_HANDSHAKE_XOR_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DHX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dhx_pkg.sv
`timescale 1ns / 1ps

package dhx_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 32;
    localparam int EXP_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 2;

    // Register file: one 32-bit register at byte address 0.
    localparam int            ADDR_W         = 3;
    localparam logic          REG_PRIV_EXP   = 1'b0;
    localparam logic [EXP_W-1:0] PRIV_EXP_RESET = 32'd7;

    // Phase codes as they appear on the result.
    localparam logic [PHASE_W-1:0] PH_MODULUS   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_GENERATOR = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PEER      = 2'd2;
    localparam logic [PHASE_W-1:0] PH_MESSAGE   = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_of_message;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  out_byte;
        logic [VALUE_W-1:0] server_key;
        logic [VALUE_W-1:0] shared_key;
        logic               key_ready;
    } t_out_item;

    // Protocol phase held by the top level.
    typedef enum logic [3:0] {
        S_PH_MODULUS   = 4'b0001,
        S_PH_GENERATOR = 4'b0010,
        S_PH_PEER      = 4'b0100,
        S_PH_MESSAGE   = 4'b1000
    } t_phase;

    // Sequencer of the modular exponentiation.
    typedef enum logic [3:0] {
        S_EXP_IDLE   = 4'b0001,
        S_EXP_REDUCE = 4'b0010,
        S_EXP_MUL    = 4'b0100,
        S_EXP_SQR    = 4'b1000
    } t_exp_state;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase s);
        logic [PHASE_W-1:0] code;
        unique case (s)
            S_PH_MODULUS:   code = PH_MODULUS;
            S_PH_GENERATOR: code = PH_GENERATOR;
            S_PH_PEER:      code = PH_PEER;
            S_PH_MESSAGE:   code = PH_MESSAGE;
            default:        code = PH_MODULUS;
        endcase
        return code;
    endfunction

endpackage

// File: sv/dhx_modmul.sv
`timescale 1ns / 1ps

// Bit-serial modular multiplier: the multiplier operand is shifted out
// most significant bit first. Each bit is a modular doubling of the
// partial result followed by a modular conditional add of i_b.
// i_b must not exceed i_m, and i_b and i_m must hold while busy.
module dhx_modmul #(
    parameter int KW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [KW-1:0] i_a,
    input  logic [KW-1:0] i_b,
    input  logic [KW-1:0] i_m,
    output logic          o_done,
    output logic [KW-1:0] o_res
);

    localparam int CNT_W = $clog2(KW);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(KW - 1);

    logic             r_busy;
    logic             r_done;
    logic             r_half;
    logic [CNT_W-1:0] r_cnt;
    logic [KW-1:0]    r_a;
    logic [KW-1:0]    r_r;

    logic [KW-1:0]    addend;
    logic [KW:0]      sum;
    logic [KW:0]      diff;
    logic [KW-1:0]    n_r;

    // One add and one trial subtract of the modulus per cycle.
    always_comb begin
        if (r_half) begin
            addend = r_a[KW-1] ? i_b : '0;
        end else begin
            addend = r_r;
        end
        sum  = {1'b0, r_r} + {1'b0, addend};
        diff = sum - {1'b0, i_m};
        n_r  = diff[KW] ? sum[KW-1:0] : diff[KW-1:0];
    end

    // Control: busy flag, half-step toggle, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_half <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_half <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_half <= ~r_half;
                if (r_half) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_BIT) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Operand shift register and partial result.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            if (r_half) begin
                r_a <= {r_a[KW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

// File: sv/dhx_modexp.sv
`timescale 1ns / 1ps

// Right-to-left square-and-multiply over the exponent, which is shifted
// out one bit per step. All products go through one shared bit-serial
// modular multiplier. The base is first reduced by a product with one.
module dhx_modexp #(
    parameter int KW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [KW-1:0]             i_base,
    input  logic [dhx_pkg::EXP_W-1:0] i_exp,
    input  logic [KW-1:0]             i_mod,
    output logic                      o_done,
    output logic [KW-1:0]             o_res
);

    localparam logic [KW-1:0] ONE = KW'(1);

    dhx_pkg::t_exp_state       r_state;
    logic                      r_go;
    logic                      r_done;
    logic [KW-1:0]             r_acc;
    logic [KW-1:0]             r_b;
    logic [KW-1:0]             r_opa;
    logic [KW-1:0]             r_opb;
    logic [dhx_pkg::EXP_W-1:0] r_e;

    logic                      mm_done;
    logic [KW-1:0]             mm_res;
    logic [dhx_pkg::EXP_W-1:0] e_cur;

    dhx_modmul #(
        .KW (KW)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .i_m     (i_mod),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    // Exponent as seen by the next step: a finished squaring consumes a bit.
    always_comb begin
        if (r_state == dhx_pkg::S_EXP_SQR) begin
            e_cur = {1'b0, r_e[dhx_pkg::EXP_W-1:1]};
        end else begin
            e_cur = r_e;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhx_pkg::S_EXP_IDLE;
            r_go    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_go   <= 1'b0;
            r_done <= 1'b0;
            unique case (r_state) inside
                dhx_pkg::S_EXP_IDLE: begin
                    if (i_start) begin
                        r_go    <= 1'b1;
                        r_state <= dhx_pkg::S_EXP_REDUCE;
                    end
                end
                dhx_pkg::S_EXP_MUL: begin
                    if (mm_done) begin
                        r_go    <= 1'b1;
                        r_state <= dhx_pkg::S_EXP_SQR;
                    end
                end
                dhx_pkg::S_EXP_REDUCE, dhx_pkg::S_EXP_SQR: begin
                    if (mm_done) begin
                        if (e_cur == '0) begin
                            r_done  <= 1'b1;
                            r_state <= dhx_pkg::S_EXP_IDLE;
                        end else if (e_cur[0]) begin
                            r_go    <= 1'b1;
                            r_state <= dhx_pkg::S_EXP_MUL;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= dhx_pkg::S_EXP_SQR;
                        end
                    end
                end
                default: begin
                    r_state <= dhx_pkg::S_EXP_IDLE;
                end
            endcase
        end
    end

    // Accumulator, running base, exponent shift register and operands.
    always_ff @(posedge i_clk) begin
        case (r_state)
            dhx_pkg::S_EXP_IDLE: begin
                if (i_start) begin
                    r_acc <= (i_mod == ONE) ? '0 : ONE;
                    r_e   <= i_exp;
                    r_opa <= i_base;
                    r_opb <= ONE;
                end
            end
            dhx_pkg::S_EXP_MUL: begin
                if (mm_done) begin
                    r_acc <= mm_res;
                    r_opa <= r_b;
                    r_opb <= r_b;
                end
            end
            default: begin
                if (mm_done) begin
                    r_b <= mm_res;
                    r_e <= e_cur;
                    if (e_cur[0]) begin
                        r_opa <= r_acc;
                    end else begin
                        r_opa <= mm_res;
                    end
                    r_opb <= mm_res;
                end
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// File: sv/dh_handshake_xor_stream.sv
`timescale 1ns / 1ps

// Channel   Signals                                      Transfer when
// -------   ------------------------------------------   ---------------------------
// in        i_in_valid, o_in_stall, i_in_data            i_in_valid && !o_in_stall
// out       o_out_valid, i_out_stall, o_out_data         o_out_valid && !i_out_stall
// config    psel, penable, pwrite, paddr, pwdata, ...    psel && penable && pwrite
//
// For a modulus word, a zero handshake word or a message byte, the result
// is registered in the output register, or in the holding slot while stalled.
// A generator or peer key word runs a modular exponentiation on one shared
// bit-serial multiplier with 1 + L + P modular products, L the bit length
// and P the set bits of the exponent. Input is stalled during that time
// and while a second result waits behind a stalled output register.
// Reset is synchronous.
module dh_handshake_xor_stream #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  dhx_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output dhx_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dhx_pkg::ADDR_W-1:0] paddr,
    input  logic [dhx_pkg::EXP_W-1:0]  pwdata,
    output logic [dhx_pkg::EXP_W-1:0]  prdata,
    output logic                       pready
);

    localparam int VW = dhx_pkg::VALUE_W;
    localparam int KW = (KEY_WIDTH < VW) ? KEY_WIDTH : VW;

    dhx_pkg::t_phase           r_phase;
    dhx_pkg::t_phase           n_phase;
    logic [KW-1:0]             r_modulus;
    logic [KW-1:0]             n_modulus;
    logic [KW-1:0]             r_server;
    logic [KW-1:0]             n_server;
    logic [KW-1:0]             r_shared;
    logic [KW-1:0]             n_shared;
    logic                      r_ended;
    logic                      n_ended;
    logic                      r_busy;
    logic                      n_busy;
    logic [dhx_pkg::EXP_W-1:0] r_priv_exp;

    logic                      r_out_valid;
    dhx_pkg::t_out_item        r_out;
    logic                      r_hold_valid;
    dhx_pkg::t_out_item        r_hold;

    logic                      accept;
    logic [KW-1:0]             word;
    logic                      word_nz;
    logic [dhx_pkg::BYTE_W-1:0] msg_byte;
    logic [dhx_pkg::BYTE_W-1:0] res_byte;
    logic                      res_wr;
    dhx_pkg::t_out_item        res;
    logic                      exp_start;
    logic                      exp_done;
    logic [KW-1:0]             exp_res;
    logic                      out_free;
    logic                      cfg_wr;

    // Input side handshake and field decode.
    assign o_in_stall = r_busy | r_hold_valid;
    assign accept     = i_in_valid & ~o_in_stall;
    assign word       = i_in_data.value[KW-1:0];
    assign word_nz    = |word;
    assign msg_byte   = i_in_data.value[dhx_pkg::BYTE_W-1:0];
    assign exp_start  = accept & word_nz &
                        ((r_phase == dhx_pkg::S_PH_GENERATOR) ||
                         (r_phase == dhx_pkg::S_PH_PEER));

    dhx_modexp #(
        .KW (KW)
    ) u_modexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_base  (word),
        .i_exp   (r_priv_exp),
        .i_mod   (r_modulus),
        .o_done  (exp_done),
        .o_res   (exp_res)
    );

    // Phase progression, key capture and the message byte decoder.
    always_comb begin
        n_phase   = r_phase;
        n_modulus = r_modulus;
        n_server  = r_server;
        n_shared  = r_shared;
        n_ended   = r_ended;
        n_busy    = r_busy;
        res_byte  = '0;
        res_wr    = 1'b0;
        if (exp_done) begin
            n_busy = 1'b0;
            res_wr = 1'b1;
            if (r_phase == dhx_pkg::S_PH_GENERATOR) begin
                n_server = exp_res;
                n_phase  = dhx_pkg::S_PH_PEER;
            end else begin
                n_shared = exp_res;
                n_phase  = dhx_pkg::S_PH_MESSAGE;
            end
        end else if (accept) begin
            unique case (r_phase) inside
                dhx_pkg::S_PH_MODULUS: begin
                    res_wr = 1'b1;
                    if (word_nz) begin
                        n_modulus = word;
                        n_phase   = dhx_pkg::S_PH_GENERATOR;
                    end
                end
                dhx_pkg::S_PH_GENERATOR, dhx_pkg::S_PH_PEER: begin
                    if (word_nz) begin
                        n_busy = 1'b1;
                    end else begin
                        res_wr = 1'b1;
                    end
                end
                dhx_pkg::S_PH_MESSAGE: begin
                    res_wr = 1'b1;
                    if (r_ended) begin
                        res_byte = msg_byte;
                    end else if (msg_byte == '0) begin
                        n_ended = 1'b1;
                    end else begin
                        res_byte = msg_byte ^ r_shared[dhx_pkg::BYTE_W-1:0];
                    end
                    if (i_in_data.last_of_message) begin
                        n_ended = 1'b0;
                    end
                end
                default: begin
                    n_phase = dhx_pkg::S_PH_MODULUS;
                end
            endcase
        end
    end

    // Result as it stands after this transfer.
    always_comb begin
        res.phase      = dhx_pkg::phase_code(n_phase);
        res.out_byte   = res_byte;
        res.server_key = VW'(n_server);
        res.shared_key = VW'(n_shared);
        res.key_ready  = (n_phase == dhx_pkg::S_PH_MESSAGE);
    end

    // Protocol state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= dhx_pkg::S_PH_MODULUS;
            r_modulus <= '0;
            r_server  <= '0;
            r_shared  <= '0;
            r_ended   <= 1'b0;
            r_busy    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_modulus <= n_modulus;
            r_server  <= n_server;
            r_shared  <= n_shared;
            r_ended   <= n_ended;
            r_busy    <= n_busy;
        end
    end

    // Output register with one holding slot behind it.
    assign out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            if (r_hold_valid && out_free) begin
                r_out_valid  <= 1'b1;
                r_hold_valid <= 1'b0;
            end else if (res_wr) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_hold_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_hold_valid && out_free) begin
            r_out <= r_hold;
        end else if (res_wr) begin
            if (out_free) begin
                r_out <= res;
            end else begin
                r_hold <= res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration register.
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == dhx_pkg::REG_PRIV_EXP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priv_exp <= dhx_pkg::PRIV_EXP_RESET;
        end else if (cfg_wr) begin
            r_priv_exp <= pwdata;
        end
    end

    assign prdata = (paddr[2] == dhx_pkg::REG_PRIV_EXP) ? r_priv_exp : '0;
    assign pready = 1'b1;

endmodule

// File: sv/dhx_checker.sv
`timescale 1ns / 1ps

`include "dh_handshake_xor_stream_macros.svh"

// Checks on the result channel of the top level.
module dhx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input dhx_pkg::t_out_item i_out_data
);

    logic in_msg;

    assign in_msg = (i_out_data.phase == dhx_pkg::PH_MESSAGE);

    // A stalled result stays offered and unchanged.
    `DHX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data), "stalled result changed")

    // The session key is flagged ready exactly in the message phase.
    `DHX_ASSERT_IMP(a_key_ready, i_clk, i_rst_n, i_out_valid, i_out_data.key_ready == in_msg, "key_ready disagrees with phase")

    // Handshake transfers produce no decoded byte.
    `DHX_ASSERT_IMP(a_byte_zero, i_clk, i_rst_n, i_out_valid && !in_msg, i_out_data.out_byte == '0, "byte outside message phase")

    // No session key exists before the message phase.
    `DHX_ASSERT_IMP(a_shared_zero, i_clk, i_rst_n, i_out_valid && !in_msg, i_out_data.shared_key == '0, "session key before peer key")

endmodule

bind dh_handshake_xor_stream dhx_checker u_dhx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
